// File: hw/rtl/bfra_pkg.sv
// Package for the best-fit region allocator: widths, status codes, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
package bfra_pkg;

  localparam int unsigned MemUnitsDef    = 256;
  localparam int unsigned JobEntriesDef  = 16;
  localparam int unsigned FreeEntriesDef = 17;

  localparam int unsigned IdW    = 8;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned StartW = 8;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StFull    = 2'd2,
    StNoJob   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SAllocScan,
    SAllocDone,
    SJobScan,
    SFreeScan,
    SRelDone,
    SShift,
    SReply
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;       // capture request, clear scan state
    logic    idx_clr;    // reset scan index
    logic    idx_inc;    // advance scan index
    logic    alloc_step; // evaluate one free entry for best fit
    logic    alloc_commit;
    logic    job_step;   // compare one job entry
    logic    rel_step;   // evaluate one free entry for neighbors
    logic    rel_commit;
    logic    shift_step; // move one job entry down
    logic    fail;       // set failure status
    status_e fail_code;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_release;
    logic size_zero;
    logic job_full;
    logic free_last;   // index at last free entry
    logic job_last;    // index at last used job entry or beyond
    logic job_empty;
    logic job_hit;     // current job entry matches
    logic slot_ok;     // release has a target free entry
    logic shift_last;
  } stat_t;

endpackage

// File: hw/rtl/bfra_ctrl.sv
// Controller FSM of the best-fit region allocator: sequences the table scans.
// Depends on bfra_pkg.
module bfra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  bfra_pkg::stat_t stat_i,
  output bfra_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  import bfra_pkg::*;

  state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (start_i) state_d = SAllocDone;
      end
      SAllocDone: begin
        // first cycle after load: dispatch
        if (stat_i.is_release) begin
          state_d = stat_i.job_empty ? SReply : SJobScan;
        end else if (stat_i.size_zero || stat_i.job_full) begin
          state_d = SReply;
        end else begin
          state_d = SAllocScan;
        end
      end
      SAllocScan: begin
        if (stat_i.free_last) state_d = SReply;
      end
      SJobScan: begin
        if (stat_i.job_hit) state_d = SFreeScan;
        else if (stat_i.job_last) state_d = SReply;
      end
      SFreeScan: begin
        if (stat_i.free_last) state_d = SRelDone;
      end
      SRelDone: begin
        state_d = stat_i.slot_ok ? SShift : SReply;
      end
      SShift: begin
        if (stat_i.shift_last) state_d = SReply;
      end
      SReply: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.fail_code = StOk;
    busy_o = (state_q != SIdle);
    done_o = (state_q == SReply);
    unique case (state_q)
      SIdle: begin
        cmd_o.load = start_i;
        cmd_o.idx_clr = 1'b1;
      end
      SAllocDone: begin
        cmd_o.idx_clr = 1'b1;
        if (stat_i.is_release) begin
          if (stat_i.job_empty) begin
            cmd_o.fail = 1'b1;
            cmd_o.fail_code = StNoJob;
          end
        end else if (stat_i.size_zero) begin
          cmd_o.fail = 1'b1;
          cmd_o.fail_code = StNoFit;
        end else if (stat_i.job_full) begin
          cmd_o.fail = 1'b1;
          cmd_o.fail_code = StFull;
        end
      end
      SAllocScan: begin
        cmd_o.alloc_step = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.free_last) cmd_o.alloc_commit = 1'b1;
      end
      SJobScan: begin
        cmd_o.job_step = 1'b1;
        if (stat_i.job_hit) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
          if (stat_i.job_last) begin
            cmd_o.fail = 1'b1;
            cmd_o.fail_code = StNoJob;
          end
        end
      end
      SFreeScan: begin
        cmd_o.rel_step = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      SRelDone: begin
        cmd_o.rel_commit = 1'b1;
        if (!stat_i.slot_ok) begin
          cmd_o.fail = 1'b1;
          cmd_o.fail_code = StFull;
        end
      end
      SShift: cmd_o.shift_step = 1'b1;
      SReply: ;
      default: ;
    endcase
  end
endmodule

// File: hw/rtl/bfra_dp.sv
// Datapath of the best-fit region allocator: free and job tables, scan index,
// best-fit and neighbor search registers, result registers. Depends on bfra_pkg.
module bfra_dp #(
  parameter int unsigned MemUnits    = bfra_pkg::MemUnitsDef,
  parameter int unsigned JobEntries  = bfra_pkg::JobEntriesDef,
  parameter int unsigned FreeEntries = bfra_pkg::FreeEntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       kind_i,
  input  logic [bfra_pkg::IdW-1:0]   job_id_i,
  input  logic [bfra_pkg::SizeW-1:0] request_size_i,
  input  bfra_pkg::cmd_t              cmd_i,
  output bfra_pkg::stat_t             stat_o,
  output logic [1:0]                 status_o,
  output logic [bfra_pkg::StartW-1:0] region_start_o,
  output logic [bfra_pkg::SizeW-1:0]  region_length_o
);
  import bfra_pkg::*;

  localparam int unsigned AW  = $clog2(MemUnits + 1);   // address/length width
  localparam int unsigned FIW = $clog2(FreeEntries);
  localparam int unsigned JIW = $clog2(JobEntries);
  localparam int unsigned JCW = $clog2(JobEntries + 1);
  localparam int unsigned XW  = (FIW > JCW) ? FIW : JCW;

  // Tables
  logic [FreeEntries-1:0] fv_q;
  logic [AW-1:0] fs_q [FreeEntries];
  logic [AW-1:0] fl_q [FreeEntries];
  logic [IdW-1:0] jid_q [JobEntries];
  logic [AW-1:0]  js_q  [JobEntries];
  logic [AW-1:0]  jl_q  [JobEntries];
  logic [JCW-1:0] jcnt_q;

  // Request and scan state
  logic           rel_q;
  logic [IdW-1:0] id_q;
  logic [AW-1:0]  size_q;
  logic           size_zero_q, size_big_q;
  logic [XW-1:0]  idx_q;
  logic           bvalid_q;
  logic [FIW-1:0] bidx_q;
  logic [AW-1:0]  blen_q, bstart_q;
  logic [JIW-1:0] jhit_q;
  logic [AW-1:0]  rs_q, rl_q;
  logic           bel_v_q, abv_v_q, inv_v_q;
  logic [FIW-1:0] bel_q, abv_q, inv_q;
  logic [AW-1:0]  bel_s_q, bel_l_q, abv_l_q;
  logic [1:0]     st_q;
  logic [AW-1:0]  ost_q, olen_q;

  logic [FIW-1:0] fi;
  logic [JIW-1:0] ji;
  logic           cur_v;
  logic [AW-1:0]  cur_s, cur_l;
  logic [AW:0]    cur_end, rel_end;
  logic           fits, better;

  assign fi = idx_q[FIW-1:0];
  assign ji = idx_q[JIW-1:0];
  assign cur_v = fv_q[fi];
  assign cur_s = fs_q[fi];
  assign cur_l = fl_q[fi];
  assign cur_end = {1'b0, cur_s} + {1'b0, cur_l};
  assign rel_end = {1'b0, rs_q} + {1'b0, rl_q};
  assign fits = cur_v && !size_big_q && (cur_l >= size_q);
  assign better = !bvalid_q || (cur_l < blen_q) || (cur_l == blen_q && cur_s < bstart_q);

  // Status to controller
  always_comb begin
    stat_o = '0;
    stat_o.is_release = rel_q;
    stat_o.size_zero  = size_zero_q;
    stat_o.job_full   = (jcnt_q == JCW'(JobEntries));
    stat_o.free_last  = (idx_q == XW'(FreeEntries - 1));
    stat_o.job_last   = ({1'b0, idx_q} + 1'b1) >= (XW+1)'(jcnt_q);
    stat_o.job_empty  = (jcnt_q == '0);
    stat_o.job_hit    = (jid_q[ji] == id_q);
    stat_o.slot_ok    = bel_v_q || abv_v_q || inv_v_q;
    stat_o.shift_last = ({1'b0, idx_q} + 2'd2) >= (XW+1)'(jcnt_q);
  end

  // Request capture, index and search registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      rel_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rel_q <= kind_i;
        id_q <= job_id_i;
        size_zero_q <= (request_size_i == '0);
        size_big_q  <= ({1'b0, request_size_i} > 10'(MemUnits)) && (SizeW >= AW);
        size_q <= AW'(request_size_i);
        bvalid_q <= 1'b0;
        bel_v_q <= 1'b0;
        abv_v_q <= 1'b0;
        inv_v_q <= 1'b0;
        st_q <= StOk;
        ost_q <= '0;
        olen_q <= '0;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc || cmd_i.shift_step) idx_q <= idx_q + 1'b1;
      if (cmd_i.fail) begin
        st_q <= cmd_i.fail_code;
        ost_q <= '0;
        olen_q <= '0;
      end
      // best fit
      if (cmd_i.alloc_step && fits && better) begin
        bvalid_q <= 1'b1;
        bidx_q <= fi;
        blen_q <= cur_l;
        bstart_q <= cur_s;
      end
      // job hit: latch region
      if (cmd_i.job_step && stat_o.job_hit) begin
        jhit_q <= ji;
        rs_q <= js_q[ji];
        rl_q <= jl_q[ji];
      end
      // neighbors and first invalid
      if (cmd_i.rel_step) begin
        if (cur_v) begin
          if (!bel_v_q && cur_end == {1'b0, rs_q}) begin
            bel_v_q <= 1'b1;
            bel_q <= fi;
            bel_s_q <= cur_s;
            bel_l_q <= cur_l;
          end else if (!abv_v_q && {1'b0, cur_s} == rel_end) begin
            abv_v_q <= 1'b1;
            abv_q <= fi;
            abv_l_q <= cur_l;
          end
        end else if (!inv_v_q) begin
          inv_v_q <= 1'b1;
          inv_q <= fi;
        end
      end
      if (cmd_i.rel_commit && stat_o.slot_ok) begin
        st_q <= StOk;
        ost_q <= bel_v_q ? bel_s_q : rs_q;
        olen_q <= AW'(rl_q + (bel_v_q ? bel_l_q : '0) + (abv_v_q ? abv_l_q : '0));
        idx_q <= XW'(jhit_q);
      end
      // alloc result on last scan step
      if (cmd_i.alloc_commit) begin
        if (fits && better) begin
          st_q <= StOk;
          ost_q <= cur_s;
          olen_q <= size_q;
        end else if (bvalid_q) begin
          st_q <= StOk;
          ost_q <= bstart_q;
          olen_q <= size_q;
        end else begin
          st_q <= StNoFit;
          ost_q <= '0;
          olen_q <= '0;
        end
      end
    end
  end

  logic           acm_hit;
  logic [FIW-1:0] acm_idx;
  logic [AW-1:0]  acm_s, acm_l;
  assign acm_hit = cmd_i.alloc_commit && ((fits && better) || bvalid_q);
  assign acm_idx = (fits && better) ? fi : bidx_q;
  assign acm_s   = (fits && better) ? cur_s : bstart_q;
  assign acm_l   = (fits && better) ? cur_l : blen_q;

  // Free table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= FreeEntries'(1);
      for (int i = 0; i < FreeEntries; i++) begin
        fs_q[i] <= '0;
        fl_q[i] <= (i == 0) ? AW'(MemUnits) : '0;
      end
    end else begin
      if (acm_hit) begin
        fs_q[acm_idx] <= acm_s + size_q;
        fl_q[acm_idx] <= acm_l - size_q;
        if (acm_l == size_q) fv_q[acm_idx] <= 1'b0;
      end
      if (cmd_i.rel_commit && stat_o.slot_ok) begin
        // drop the upper neighbor only when the lower one takes the merge
        if (abv_v_q && bel_v_q) fv_q[abv_q] <= 1'b0;
        fv_q[bel_v_q ? bel_q : (abv_v_q ? abv_q : inv_q)] <= 1'b1;
        fs_q[bel_v_q ? bel_q : (abv_v_q ? abv_q : inv_q)] <= bel_v_q ? bel_s_q : rs_q;
        fl_q[bel_v_q ? bel_q : (abv_v_q ? abv_q : inv_q)] <=
          AW'(rl_q + (bel_v_q ? bel_l_q : '0) + (abv_v_q ? abv_l_q : '0));
      end
    end
  end

  // Job table: append on allocate, shift down one entry a cycle on release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jcnt_q <= '0;
    end else begin
      if (acm_hit) begin
        jid_q[jcnt_q[JIW-1:0]] <= id_q;
        js_q[jcnt_q[JIW-1:0]]  <= acm_s;
        jl_q[jcnt_q[JIW-1:0]]  <= size_q;
        jcnt_q <= jcnt_q + 1'b1;
      end
      if (cmd_i.shift_step) begin
        if (({1'b0, idx_q} + 1'b1) < (XW+1)'(jcnt_q)) begin
          jid_q[ji] <= jid_q[JIW'(idx_q + 1'b1)];
          js_q[ji]  <= js_q[JIW'(idx_q + 1'b1)];
          jl_q[ji]  <= jl_q[JIW'(idx_q + 1'b1)];
        end
        if (stat_o.shift_last) jcnt_q <= jcnt_q - 1'b1;
      end
    end
  end

  assign status_o = st_q;
  assign region_start_o = ost_q[StartW-1:0];
  assign region_length_o = SizeW'(olen_q);
endmodule

// File: hw/rtl/best_fit_region_allocator_top.sv
// Top level of the best-fit region allocator: controller plus datapath.
// Depends on bfra_pkg, bfra_ctrl, bfra_dp.
//
// Usage: drive kind_i, job_id_i and request_size_i with start high while
// busy is low; the request is taken at that edge. busy stays high until
// the result. One result appears with done_o high for exactly one cycle on
// status_o, region_start_o and region_length_o; it cannot be held off.
// An allocate walks the free table one entry a cycle. A release walks the
// job table up to the match, then the free table, then shifts the entries
// above the match down one a cycle. busy drops after the result cycle, and
// the next request can then be taken; these table walks set the rate and
// one request is in flight at a time. Requests rejected at dispatch skip
// the table walks and go straight to the result.
// Reset: all memory is one free region at address 0, job table empty.
module best_fit_region_allocator_top #(
  parameter int unsigned MemUnits    = bfra_pkg::MemUnitsDef,
  parameter int unsigned JobEntries  = bfra_pkg::JobEntriesDef,
  parameter int unsigned FreeEntries = bfra_pkg::FreeEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [bfra_pkg::IdW-1:0]    job_id_i,
  input  logic [bfra_pkg::SizeW-1:0]  request_size_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [bfra_pkg::StartW-1:0] region_start_o,
  output logic [bfra_pkg::SizeW-1:0]  region_length_o
);
  import bfra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfra_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .cmd_o(cmd),
    .busy_o(busy), .done_o(done_o)
  );

  bfra_dp #(.MemUnits(MemUnits), .JobEntries(JobEntries), .FreeEntries(FreeEntries)) u_dp (
    .clk_i, .rst_ni, .kind_i, .job_id_i, .request_size_i, .cmd_i(cmd), .stat_o(stat),
    .status_o, .region_start_o, .region_length_o
  );

`ifndef SYNTH
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result while not busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (region_length_o == '0 && region_start_o == '0))
    else $error("failed request with nonzero region");
`endif
endmodule
